// ===== rtl/wem_pkg.sv =====
// Package for the window error metrics block: payload structs, register
// indexes, fixed field widths and the control structs shared by the modules.
// Depends on nothing; every other file of the block uses it by scoped names.
`default_nettype none

package wem_pkg;

  // Default values of the top level parameters.
  localparam int DEF_MAX_DIM      = 4096;
  localparam int DEF_MAX_CHANNELS = 4;
  localparam int DEF_SAMPLE_BITS  = 16;
  localparam int DEF_FRAC_BITS    = 8;

  // Fixed field and accumulator widths.
  localparam int SAMPLE_W = 16;
  localparam int PIX_W    = 12;
  localparam int CHAN_W   = 2;
  localparam int OUT_W    = 24;
  localparam int CNT_W    = 27;
  localparam int ABS_W    = 42;
  localparam int SQ_W     = 58;

  // Largest error value; larger results saturate here.
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // Bits of the integer part of the mean square before the root saturates.
  localparam int QLIM_W = 32;

  // Width of the signed clipping arithmetic (covers MAX_DIM up to 16384).
  localparam int CLIP_W = 16;

  // Configuration port.
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CC_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CORNER1_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER1_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER2_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER2_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd6;

  // Step modes of the shared compare-subtract unit.
  localparam logic MODE_DIV  = 1'b0;
  localparam logic MODE_SQRT = 1'b1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic [PIX_W-1:0]    pixel_x;
    logic [PIX_W-1:0]    pixel_y;
    logic [CHAN_W-1:0]   channel;
    logic                last_sample;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] mean_abs_error;
    logic [OUT_W-1:0] rms_error;
    logic             window_empty;
    logic [CNT_W-1:0] sample_count;
  } out_t;

  // Window status toward the sequencer and the accumulator.
  typedef struct packed {
    logic nonempty;
    logic hit;
  } win_flags_t;

  // Strobes from the sequencer to the accumulator.
  typedef struct packed {
    logic load;
    logic diff;
    logic square;
    logic add;
    logic clear;
  } accum_ctl_t;

  // Clipped bounds along one axis.
  typedef struct packed {
    logic                     ok;
    logic signed [CLIP_W-1:0] lo;
    logic signed [CLIP_W-1:0] hi;
  } axis_t;

endpackage

`default_nettype wire

// ===== rtl/window_error_metrics_top.sv =====
// Top level of the window error metrics block: ports, output register and
// checks. Depends on wem_pkg, wem_window, wem_accum and wem_seq.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  wem_pkg::in_t  in_data
//   out       output     out_valid/out_stall  wem_pkg::out_t out_data
//   cfg       input      cfg_we               cfg_index, cfg_data
//
// A transfer that does not end a frame steps through accept, difference, square and add.
// Unless its window is empty, the last one then forms the normalizer and runs the two
// divisions and the square root (skipped when it saturates) on the shared compare-subtract
// unit before handing the result over.
// Synchronous reset restores the register defaults and clears the sums; no clearing pass.
// A result waits in the output register under out_stall while the next transfer proceeds.
`default_nettype none

module window_error_metrics_top #(
  parameter int MAX_DIM      = wem_pkg::DEF_MAX_DIM,
  parameter int MAX_CHANNELS = wem_pkg::DEF_MAX_CHANNELS,
  parameter int SAMPLE_BITS  = wem_pkg::DEF_SAMPLE_BITS,
  parameter int FRAC_BITS    = wem_pkg::DEF_FRAC_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire wem_pkg::in_t                   in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output wem_pkg::out_t                       out_data,
  input  wire logic                           cfg_we,
  input  wire logic [wem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wem_pkg::CFG_W-1:0]      cfg_data
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CH_W  = $clog2(MAX_CHANNELS + 1);

  wem_pkg::win_flags_t          flags;
  wem_pkg::accum_ctl_t          acc_ctl;
  wem_pkg::out_t                res;
  logic [DIM_W-1:0]             span_x, span_y;
  logic [CH_W-1:0]              nch;
  logic [wem_pkg::ABS_W-1:0]    sum_abs;
  logic [wem_pkg::SQ_W-1:0]     sum_sq;
  logic [wem_pkg::CNT_W-1:0]    count;
  logic                         busy, res_valid, res_take, in_xfer;

  wem_window #(
    .MAX_DIM      (MAX_DIM),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_x   (in_data.pixel_x),
    .pixel_y   (in_data.pixel_y),
    .channel   (in_data.channel),
    .flags     (flags),
    .span_x    (span_x),
    .span_y    (span_y),
    .nch       (nch)
  );

  wem_accum #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .ctl      (acc_ctl),
    .sample_a (in_data.sample_a),
    .sample_b (in_data.sample_b),
    .hit      (flags.hit),
    .sum_abs  (sum_abs),
    .sum_sq   (sum_sq),
    .count    (count)
  );

  wem_seq #(
    .MAX_DIM      (MAX_DIM),
    .MAX_CHANNELS (MAX_CHANNELS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (in_xfer),
    .last_in   (in_data.last_sample),
    .nonempty  (flags.nonempty),
    .span_x    (span_x),
    .span_y    (span_y),
    .nch       (nch),
    .sum_abs   (sum_abs),
    .sum_sq    (sum_sq),
    .count     (count),
    .res_take  (res_take),
    .busy      (busy),
    .acc_ctl   (acc_ctl),
    .res_valid (res_valid),
    .res       (res)
  );

  // Input transfer is taken only while the sequencer is idle.
  assign in_stall = busy;
  assign in_xfer  = in_valid && !in_stall;

  // Output register: loads when empty or when its result transfers.
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

  // An empty window reports zero errors.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.window_empty |->
      (out_data.mean_abs_error == '0) && (out_data.rms_error == '0))
    else $error("empty window result carries nonzero errors");

  // Handing a result to the output register clears the frame sums.
  a_clear_after_take: assert property (@(posedge clk) disable iff (rst)
    res_take |=> (count == '0) && (sum_abs == '0) && (sum_sq == '0))
    else $error("frame sums not cleared after result transfer");

  // A finished result waits in the sequencer until the output register frees.
  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_take |=> res_valid && $stable(res))
    else $error("pending result lost or changed");

endmodule

`default_nettype wire

// ===== rtl/wem_window.sv =====
// Configuration registers and window logic: orders and clips the corners,
// gives the window spans, channel count and the in-window test of a sample.
// Depends on wem_pkg.
`default_nettype none

module wem_window #(
  parameter int MAX_DIM      = wem_pkg::DEF_MAX_DIM,
  parameter int MAX_CHANNELS = wem_pkg::DEF_MAX_CHANNELS,
  localparam int DIM_W = $clog2(MAX_DIM + 1),
  localparam int CH_W  = $clog2(MAX_CHANNELS + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [wem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wem_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic [wem_pkg::PIX_W-1:0]      pixel_x,
  input  wire logic [wem_pkg::PIX_W-1:0]      pixel_y,
  input  wire logic [wem_pkg::CHAN_W-1:0]     channel,
  output wem_pkg::win_flags_t                 flags,
  output logic [DIM_W-1:0]                    span_x,
  output logic [DIM_W-1:0]                    span_y,
  output logic [CH_W-1:0]                     nch
);

  localparam int CW = wem_pkg::CLIP_W;

  logic signed [wem_pkg::CFG_W-1:0] corner1_x, corner1_y, corner2_x, corner2_y;
  logic [wem_pkg::CFG_W-1:0]        image_width, image_height;
  logic [wem_pkg::CC_W-1:0]         channel_count;

  wem_pkg::axis_t      ax, ay;
  logic signed [CW-1:0] px_s, py_s;
  logic                 in_x, in_y, in_ch, win_open;

  // Order the corners, then clip them to [0, size-1] with size capped at MAX_DIM.
  function automatic wem_pkg::axis_t clip_axis(
    input logic signed [wem_pkg::CFG_W-1:0] c1,
    input logic signed [wem_pkg::CFG_W-1:0] c2,
    input logic [wem_pkg::CFG_W-1:0]        size
  );
    logic signed [CW-1:0] a, b, lim;
    logic [CW-1:0]        s;
    wem_pkg::axis_t       r;
    a = {{(CW - wem_pkg::CFG_W){c1[wem_pkg::CFG_W-1]}}, c1};
    b = {{(CW - wem_pkg::CFG_W){c2[wem_pkg::CFG_W-1]}}, c2};
    if (b < a) begin
      r.lo = b;
      r.hi = a;
    end else begin
      r.lo = a;
      r.hi = b;
    end
    s = CW'(size);
    if (s > CW'(MAX_DIM)) begin
      s = CW'(MAX_DIM);
    end
    lim = $signed(s) - CW'(1);
    if (r.lo < 0) begin
      r.lo = '0;
    end
    if (r.hi > lim) begin
      r.hi = lim;
    end
    r.ok = (r.lo <= r.hi);
    return r;
  endfunction

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      corner1_x     <= '0;
      corner1_y     <= '0;
      corner2_x     <= 13'sd4095;
      corner2_y     <= 13'sd4095;
      image_width   <= 13'd4096;
      image_height  <= 13'd4096;
      channel_count <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        wem_pkg::REG_CORNER1_X:     corner1_x     <= $signed(cfg_data);
        wem_pkg::REG_CORNER1_Y:     corner1_y     <= $signed(cfg_data);
        wem_pkg::REG_CORNER2_X:     corner2_x     <= $signed(cfg_data);
        wem_pkg::REG_CORNER2_Y:     corner2_y     <= $signed(cfg_data);
        wem_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        wem_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        wem_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[wem_pkg::CC_W-1:0];
        default: ;
      endcase
    end
  end

  // Clipped window and effective channel count.
  always_comb begin
    ax = clip_axis(corner1_x, corner2_x, image_width);
    ay = clip_axis(corner1_y, corner2_y, image_height);
    if (32'(channel_count) > MAX_CHANNELS) begin
      nch = CH_W'(MAX_CHANNELS);
    end else begin
      nch = CH_W'(channel_count);
    end
    span_x   = DIM_W'(ax.hi - ax.lo + CW'(1));
    span_y   = DIM_W'(ay.hi - ay.lo + CW'(1));
    win_open = ax.ok && ay.ok && (nch != '0);
  end

  // In-window test of the sample on the input channel.
  always_comb begin
    px_s  = $signed(CW'(pixel_x));
    py_s  = $signed(CW'(pixel_y));
    in_x  = (px_s >= ax.lo) && (px_s <= ax.hi);
    in_y  = (py_s >= ay.lo) && (py_s <= ay.hi);
    in_ch = (CH_W + 2)'(channel) < (CH_W + 2)'(nch);
    flags.nonempty = win_open;
    flags.hit      = win_open && in_x && in_y && in_ch;
  end

endmodule

`default_nettype wire

// ===== rtl/wem_accum.sv =====
// Sample datapath and frame accumulators: absolute difference, its square,
// and the running sums and count, stepped by strobes from the sequencer.
// Depends on wem_pkg.
`default_nettype none

module wem_accum #(
  parameter int SAMPLE_BITS = wem_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire wem_pkg::accum_ctl_t           ctl,
  input  wire logic [wem_pkg::SAMPLE_W-1:0]  sample_a,
  input  wire logic [wem_pkg::SAMPLE_W-1:0]  sample_b,
  input  wire logic                          hit,
  output logic [wem_pkg::ABS_W-1:0]          sum_abs,
  output logic [wem_pkg::SQ_W-1:0]           sum_sq,
  output logic [wem_pkg::CNT_W-1:0]          count
);

  localparam int SW = wem_pkg::SAMPLE_W;
  localparam logic [SW-1:0] SMASK = SW'(((SW + 1)'(1) << SAMPLE_BITS) - (SW + 1)'(1));

  logic [SW-1:0]   a_r, b_r, diff;
  logic [2*SW-1:0] diff_sq;
  logic            hit_r;

  // Operand capture, difference and square, one step per strobe.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r   <= sample_a & SMASK;
      b_r   <= sample_b & SMASK;
      hit_r <= hit;
    end
    if (ctl.diff) begin
      diff <= (a_r > b_r) ? (a_r - b_r) : (b_r - a_r);
    end
    if (ctl.square) begin
      diff_sq <= diff * diff;
    end
  end

  // Running sums; they wrap at their widths and clear after each result.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      sum_abs <= '0;
      sum_sq  <= '0;
      count   <= '0;
    end else if (ctl.add && hit_r) begin
      sum_abs <= sum_abs + wem_pkg::ABS_W'(diff);
      sum_sq  <= sum_sq + wem_pkg::SQ_W'(diff_sq);
      count   <= count + wem_pkg::CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wem_cs_unit.sv =====
// Shared compare-subtract unit: one step of restoring division or of the
// digit-by-digit square root, selected by the step mode.
// Depends on wem_pkg.
`default_nettype none

module wem_cs_unit #(
  parameter int UNIT_W = 28,
  parameter int N_W    = 27,
  parameter int RT_W   = 24
) (
  input  wire logic              mode,
  input  wire logic [UNIT_W-1:0] rem,
  input  wire logic [1:0]        top_bits,
  input  wire logic [RT_W-1:0]   root,
  input  wire logic [N_W-1:0]    divisor,
  output logic                   ge,
  output logic [UNIT_W-1:0]      rem_out
);

  logic [UNIT_W-1:0] shifted, subtrahend, diff;

  // Bring down one dividend bit or two radicand bits, then trial subtract.
  always_comb begin
    if (mode == wem_pkg::MODE_SQRT) begin
      shifted    = {rem[UNIT_W-3:0], top_bits};
      subtrahend = UNIT_W'({root, 2'b01});
    end else begin
      shifted    = {rem[UNIT_W-2:0], top_bits[1]};
      subtrahend = UNIT_W'(divisor);
    end
    diff    = shifted - subtrahend;
    ge      = (shifted >= subtrahend);
    rem_out = ge ? diff : shifted;
  end

endmodule

`default_nettype wire

// ===== rtl/wem_seq.sv =====
// Sequencer: steps the sample datapath, forms the normalizer, and runs both
// divisions and the square root through the shared compare-subtract unit.
// Depends on wem_pkg and wem_cs_unit.
`default_nettype none

module wem_seq #(
  parameter int MAX_DIM      = wem_pkg::DEF_MAX_DIM,
  parameter int MAX_CHANNELS = wem_pkg::DEF_MAX_CHANNELS,
  parameter int FRAC_BITS    = wem_pkg::DEF_FRAC_BITS,
  localparam int DIM_W = $clog2(MAX_DIM + 1),
  localparam int CH_W  = $clog2(MAX_CHANNELS + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic                       last_in,
  input  wire logic                       nonempty,
  input  wire logic [DIM_W-1:0]           span_x,
  input  wire logic [DIM_W-1:0]           span_y,
  input  wire logic [CH_W-1:0]            nch,
  input  wire logic [wem_pkg::ABS_W-1:0]  sum_abs,
  input  wire logic [wem_pkg::SQ_W-1:0]   sum_sq,
  input  wire logic [wem_pkg::CNT_W-1:0]  count,
  input  wire logic                       res_take,
  output logic                            busy,
  output wem_pkg::accum_ctl_t             acc_ctl,
  output logic                            res_valid,
  output wem_pkg::out_t                   res
);

  localparam int  N_W    = $clog2(longint'(MAX_DIM) * longint'(MAX_DIM) *
                                  longint'(MAX_CHANNELS) + 64'd1);
  localparam int  PR_W   = 2 * DIM_W;
  localparam int  NF_W   = PR_W + CH_W;
  localparam int  DIV_W  = wem_pkg::SQ_W + 2 * FRAC_BITS;
  localparam int  RT_W   = wem_pkg::QLIM_W / 2 + FRAC_BITS;
  localparam int  UNIT_W = (N_W + 1 > RT_W + 3) ? N_W + 1 : RT_W + 3;
  localparam int  IT_W   = $clog2(DIV_W + 1);
  localparam int  OW     = wem_pkg::OUT_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_ADD   = 4'd3;
  localparam logic [3:0] S_NMUL1 = 4'd4;
  localparam logic [3:0] S_NMUL2 = 4'd5;
  localparam logic [3:0] S_DIVA  = 4'd6;
  localparam logic [3:0] S_DIVS  = 4'd7;
  localparam logic [3:0] S_SQRT  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]        state, state_next;
  logic              last_flag, last_flag_next;
  logic [PR_W-1:0]   prod_wh, prod_wh_next;
  logic [N_W-1:0]    n_val, n_val_next;
  logic [DIV_W-1:0]  work, work_next, work_div;
  logic [UNIT_W-1:0] rem, rem_next, step_rem;
  logic [RT_W-1:0]   root, root_next, root_step;
  logic [IT_W-1:0]   iter, iter_next;
  logic [OW-1:0]     mae, mae_next, rms, rms_next;
  logic              empty, empty_next;
  logic              step_ge, step_mode;
  logic [NF_W-1:0]   n_full;
  logic [RT_W+OW-1:0] root_ext;

  // The one arithmetic unit shared by all three long operations.
  wem_cs_unit #(
    .UNIT_W (UNIT_W),
    .N_W    (N_W),
    .RT_W   (RT_W)
  ) u_cs (
    .mode     (step_mode),
    .rem      (rem),
    .top_bits (work[DIV_W-1:DIV_W-2]),
    .root     (root),
    .divisor  (n_val),
    .ge       (step_ge),
    .rem_out  (step_rem)
  );

  assign step_mode = (state == S_SQRT) ? wem_pkg::MODE_SQRT : wem_pkg::MODE_DIV;
  assign work_div  = {work[DIV_W-2:0], step_ge};
  assign root_step = {root[RT_W-2:0], step_ge};
  assign n_full    = NF_W'(prod_wh) * NF_W'(nch);
  assign root_ext  = (RT_W + OW)'(root_step);

  assign busy      = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  // Result fields.
  always_comb begin
    res.mean_abs_error = mae;
    res.rms_error      = rms;
    res.window_empty   = empty;
    res.sample_count   = count;
  end

  // Next-state and datapath control.
  always_comb begin
    state_next     = state;
    last_flag_next = last_flag;
    prod_wh_next   = prod_wh;
    n_val_next     = n_val;
    work_next      = work;
    rem_next       = rem;
    root_next      = root;
    iter_next      = iter;
    mae_next       = mae;
    rms_next       = rms;
    empty_next     = empty;
    acc_ctl        = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          acc_ctl.load   = 1'b1;
          last_flag_next = last_in;
          state_next     = S_DIFF;
        end
      end
      S_DIFF: begin
        acc_ctl.diff = 1'b1;
        state_next   = S_SQ;
      end
      S_SQ: begin
        acc_ctl.square = 1'b1;
        state_next     = S_ADD;
      end
      S_ADD: begin
        acc_ctl.add = 1'b1;
        if (!last_flag) begin
          state_next = S_IDLE;
        end else if (!nonempty) begin
          empty_next = 1'b1;
          mae_next   = '0;
          rms_next   = '0;
          state_next = S_DONE;
        end else begin
          empty_next = 1'b0;
          state_next = S_NMUL1;
        end
      end
      // Normalizer: columns times rows, then times channels.
      S_NMUL1: begin
        prod_wh_next = PR_W'(span_x) * PR_W'(span_y);
        state_next   = S_NMUL2;
      end
      S_NMUL2: begin
        n_val_next = N_W'(n_full);
        work_next  = DIV_W'(sum_abs) << FRAC_BITS;
        rem_next   = '0;
        iter_next  = IT_W'(DIV_W);
        state_next = S_DIVA;
      end
      // Mean absolute error: one quotient bit per cycle.
      S_DIVA: begin
        work_next = work_div;
        rem_next  = step_rem;
        iter_next = iter - IT_W'(1);
        if (iter == IT_W'(1)) begin
          mae_next   = (work_div > DIV_W'(wem_pkg::OUT_MAX)) ? wem_pkg::OUT_MAX
                                                             : work_div[OW-1:0];
          work_next  = DIV_W'(sum_sq) << (2 * FRAC_BITS);
          rem_next   = '0;
          iter_next  = IT_W'(DIV_W);
          state_next = S_DIVS;
        end
      end
      // Mean square with fraction bits, then the saturation check.
      S_DIVS: begin
        work_next = work_div;
        rem_next  = step_rem;
        iter_next = iter - IT_W'(1);
        if (iter == IT_W'(1)) begin
          if (work_div[DIV_W-1:2*RT_W] != '0) begin
            rms_next   = wem_pkg::OUT_MAX;
            state_next = S_DONE;
          end else begin
            work_next  = DIV_W'(work_div[2*RT_W-1:0]) << (DIV_W - 2 * RT_W);
            rem_next   = '0;
            root_next  = '0;
            iter_next  = IT_W'(RT_W);
            state_next = S_SQRT;
          end
        end
      end
      // Square root: one root bit per cycle.
      S_SQRT: begin
        work_next = work << 2;
        rem_next  = step_rem;
        root_next = root_step;
        iter_next = iter - IT_W'(1);
        if (iter == IT_W'(1)) begin
          rms_next   = (root_ext > (RT_W + OW)'(wem_pkg::OUT_MAX)) ? wem_pkg::OUT_MAX
                                                                   : OW'(root_step);
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          acc_ctl.clear = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    last_flag <= last_flag_next;
    prod_wh   <= prod_wh_next;
    n_val     <= n_val_next;
    work      <= work_next;
    rem       <= rem_next;
    root      <= root_next;
    iter      <= iter_next;
    mae       <= mae_next;
    rms       <= rms_next;
    empty     <= empty_next;
  end

endmodule

`default_nettype wire

// ===== test/window_error_metrics_top_test.sv =====
// Self-checking testbench for window_error_metrics_top: a directed table, then random
// frames under random window setups, scored against the table's expected results or an in-bench model of the metrics.
// Depends on wem_pkg and the window_error_metrics_top RTL; needs no files or arguments.
module window_error_metrics_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM      = wem_pkg::DEF_MAX_DIM;
  localparam int MAX_CHANNELS = wem_pkg::DEF_MAX_CHANNELS;
  localparam int FRAC         = wem_pkg::DEF_FRAC_BITS;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASE_ITEMS  = 160;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 1500;
  localparam int CYCLE_LIMIT  = 3_000_000;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_SAMPLE,
    ROW_CHECKED
  } row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [wem_pkg::CFG_IDX_W-1:0]   index;
    logic [wem_pkg::CFG_W-1:0]       value;
    wem_pkg::in_t                    sample;
    wem_pkg::out_t                   result;
  } row_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  wem_pkg::in_t                  in_data;
  logic                          out_valid;
  logic                          out_stall;
  wem_pkg::out_t                 out_data;
  logic                          cfg_we;
  logic [wem_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [wem_pkg::CFG_W-1:0]     cfg_data;

  // Window setup and running sums as the block should hold them.
  logic signed [wem_pkg::CFG_W-1:0] corner_x1, corner_y1, corner_x2, corner_y2;
  logic [wem_pkg::CFG_W-1:0]        img_w, img_h;
  logic [wem_pkg::CC_W-1:0]         chan_cfg;
  logic [wem_pkg::ABS_W-1:0]        abs_sum;
  logic [wem_pkg::SQ_W-1:0]         sq_sum;
  logic [wem_pkg::CNT_W-1:0]        hit_count;

  wem_pkg::out_t pending_metrics [$];
  int   fail_count = 0;
  bit   calm_send = 1'b0;
  bit   calm_recv = 1'b0;
  bit   press_go = 1'b0;
  logic long_hold;

  // Directed rows: reset window, channel filtering, a one-pixel window with saturation, empty
  // windows from channel count, corners and image size, then oversized settings and a 1x1 image.
  row_t directed_rows [$] = '{
    '{ROW_SAMPLE,  '0, '0, '{16'hFFFF, 16'h0000, 12'd4095, 12'd4095, 2'd3, 1'b0}, '0},
    '{ROW_SAMPLE,  '0, '0, '{16'hFFFF, 16'h0000, 12'd4095, 12'd4095, 2'd0, 1'b1}, '0},
    '{ROW_CHECKED, '0, '0, '{16'h0000, 16'h0000, 12'd0, 12'd0, 2'd0, 1'b1},
      '{24'd0, 24'd0, 1'b0, 27'd1}},
    '{ROW_CHECKED, '0, '0, '{16'hFFFF, 16'h0000, 12'd0, 12'd4095, 2'd2, 1'b1},
      '{24'd0, 24'd0, 1'b0, 27'd0}},
    '{ROW_REG, wem_pkg::REG_CORNER1_X, 13'd5, '0, '0},
    '{ROW_REG, wem_pkg::REG_CORNER1_Y, 13'd7, '0, '0},
    '{ROW_REG, wem_pkg::REG_CORNER2_X, 13'd5, '0, '0},
    '{ROW_REG, wem_pkg::REG_CORNER2_Y, 13'd7, '0, '0},
    '{ROW_SAMPLE,  '0, '0, '{16'hFFFF, 16'h0000, 12'd4, 12'd7, 2'd0, 1'b0}, '0},
    '{ROW_SAMPLE,  '0, '0, '{16'hFFFF, 16'h0000, 12'd5, 12'd8, 2'd0, 1'b0}, '0},
    '{ROW_SAMPLE,  '0, '0, '{16'hFFFF, 16'h0000, 12'd5, 12'd7, 2'd0, 1'b0}, '0},
    '{ROW_CHECKED, '0, '0, '{16'h0000, 16'hFFFF, 12'd5, 12'd7, 2'd0, 1'b1},
      '{wem_pkg::OUT_MAX, wem_pkg::OUT_MAX, 1'b0, 27'd2}},
    '{ROW_CHECKED, '0, '0, '{16'd100, 16'd36, 12'd5, 12'd7, 2'd0, 1'b1},
      '{24'd16384, 24'd16384, 1'b0, 27'd1}},
    '{ROW_REG, wem_pkg::REG_CHANNEL_COUNT, 13'd0, '0, '0},
    '{ROW_CHECKED, '0, '0, '{16'hFFFF, 16'h0000, 12'd5, 12'd7, 2'd0, 1'b1},
      '{24'd0, 24'd0, 1'b1, 27'd0}},
    '{ROW_REG, wem_pkg::REG_CHANNEL_COUNT, 13'd7, '0, '0},
    '{ROW_REG, wem_pkg::REG_CORNER1_X, 13'h0FFF, '0, '0},
    '{ROW_REG, wem_pkg::REG_CORNER2_X, 13'h1000, '0, '0},
    '{ROW_REG, wem_pkg::REG_IMAGE_WIDTH, 13'h1FFF, '0, '0},
    '{ROW_REG, wem_pkg::REG_CORNER1_Y, 13'h1FFF, '0, '0},
    '{ROW_REG, wem_pkg::REG_CORNER2_Y, 13'h1000, '0, '0},
    '{ROW_CHECKED, '0, '0, '{16'hFFFF, 16'hFFFF, 12'd4095, 12'd0, 2'd3, 1'b1},
      '{24'd0, 24'd0, 1'b1, 27'd0}},
    '{ROW_REG, wem_pkg::REG_CORNER1_Y, 13'h0FFF, '0, '0},
    '{ROW_REG, wem_pkg::REG_IMAGE_HEIGHT, 13'd0, '0, '0},
    '{ROW_CHECKED, '0, '0, '{16'h0000, 16'h0000, 12'd0, 12'd0, 2'd0, 1'b1},
      '{24'd0, 24'd0, 1'b1, 27'd0}},
    '{ROW_REG, wem_pkg::REG_IMAGE_HEIGHT, 13'd4096, '0, '0},
    '{ROW_SAMPLE,  '0, '0, '{16'hFFFF, 16'h0000, 12'd4095, 12'd4095, 2'd3, 1'b0}, '0},
    '{ROW_SAMPLE,  '0, '0, '{16'h0000, 16'hFFFF, 12'd0, 12'd0, 2'd2, 1'b0}, '0},
    '{ROW_SAMPLE,  '0, '0, '{16'h8000, 16'h7FFF, 12'd2048, 12'd1, 2'd1, 1'b1}, '0},
    '{ROW_REG, wem_pkg::REG_IMAGE_WIDTH, 13'd1, '0, '0},
    '{ROW_REG, wem_pkg::REG_IMAGE_HEIGHT, 13'd1, '0, '0},
    '{ROW_SAMPLE,  '0, '0, '{16'hAAAA, 16'h5555, 12'd0, 12'd0, 2'd0, 1'b0}, '0},
    '{ROW_SAMPLE,  '0, '0, '{16'h5555, 16'hAAAA, 12'd0, 12'd0, 2'd3, 1'b0}, '0},
    '{ROW_SAMPLE,  '0, '0, '{16'h0001, 16'h0000, 12'd1, 12'd0, 2'd0, 1'b0}, '0},
    '{ROW_SAMPLE,  '0, '0, '{16'hFFFF, 16'hFFFE, 12'd0, 12'd0, 2'd1, 1'b1}, '0}
  };

  window_error_metrics_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Orders two corners and clips them to the image along one axis; false when empty.
  function automatic bit bound_axis(input logic signed [wem_pkg::CFG_W-1:0] c1,
                                    input logic signed [wem_pkg::CFG_W-1:0] c2,
                                    input logic [wem_pkg::CFG_W-1:0] size,
                                    output int lo, output int hi);
    int span;
    lo = (c1 < c2) ? c1 : c2;
    hi = (c1 < c2) ? c2 : c1;
    span = (size > MAX_DIM) ? MAX_DIM : size;
    if (lo < 0) lo = 0;
    if (hi > span - 1) hi = span - 1;
    return lo <= hi;
  endfunction

  function automatic int active_channels();
    return (chan_cfg > MAX_CHANNELS) ? MAX_CHANNELS : chan_cfg;
  endfunction

  // Largest r with r*r <= v, found one bit at a time from the top.
  function automatic logic [31:0] int_root(input logic [63:0] v);
    logic [31:0] r, t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (64'(t) * 64'(t) <= v) r = t;
    end
    return r;
  endfunction

  // Folds one sample into the sums; on the frame's last sample forms the metrics and clears.
  function automatic void predict_metrics(input wem_pkg::in_t s, output bit took,
                                          output bit done, output wem_pkg::out_t res);
    int                                 xl, xh, yl, yh, px, py, nch;
    bit                                 okx, oky, open_win;
    logic [wem_pkg::SAMPLE_W-1:0]       d;
    longint unsigned                    n, mae, q, msq;
    logic [wem_pkg::SQ_W+2*FRAC-1:0]    wide;
    logic [31:0]                        root;
    okx = bound_axis(corner_x1, corner_x2, img_w, xl, xh);
    oky = bound_axis(corner_y1, corner_y2, img_h, yl, yh);
    nch = active_channels();
    open_win = okx && oky && nch != 0;
    px = s.pixel_x;
    py = s.pixel_y;
    took = open_win && px >= xl && px <= xh && py >= yl && py <= yh && s.channel < nch;
    if (took) begin
      d = (s.sample_a > s.sample_b) ? s.sample_a - s.sample_b : s.sample_b - s.sample_a;
      abs_sum = abs_sum + wem_pkg::ABS_W'(d);
      sq_sum = sq_sum + wem_pkg::SQ_W'(64'(d) * 64'(d));
      hit_count = hit_count + 1'b1;
    end
    done = s.last_sample;
    res = '0;
    if (done) begin
      res.window_empty = !open_win;
      res.sample_count = hit_count;
      if (open_win) begin
        n = 64'(xh - xl + 1) * 64'(yh - yl + 1) * 64'(nch);
        mae = (64'(abs_sum) << FRAC) / n;
        res.mean_abs_error = (mae > wem_pkg::OUT_MAX) ? wem_pkg::OUT_MAX
                                                      : mae[wem_pkg::OUT_W-1:0];
        q = 64'(sq_sum) / n;
        if (q > 64'hFFFF_FFFF) begin
          res.rms_error = wem_pkg::OUT_MAX;
        end else begin
          wide = (wem_pkg::SQ_W+2*FRAC)'(sq_sum) << (2 * FRAC);
          msq = 64'(wide / (wem_pkg::SQ_W+2*FRAC)'(n));
          root = int_root(msq);
          res.rms_error = (root > wem_pkg::OUT_MAX) ? wem_pkg::OUT_MAX
                                                    : root[wem_pkg::OUT_W-1:0];
        end
      end
      abs_sum = '0;
      sq_sum = '0;
      hit_count = '0;
    end
  endfunction

  // One register write; the next transfer or drain lowers the enable.
  task automatic write_reg(input logic [wem_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wem_pkg::CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      wem_pkg::REG_CORNER1_X:     corner_x1 = value;
      wem_pkg::REG_CORNER1_Y:     corner_y1 = value;
      wem_pkg::REG_CORNER2_X:     corner_x2 = value;
      wem_pkg::REG_CORNER2_Y:     corner_y2 = value;
      wem_pkg::REG_IMAGE_WIDTH:   img_w = value;
      wem_pkg::REG_IMAGE_HEIGHT:  img_h = value;
      wem_pkg::REG_CHANNEL_COUNT: chan_cfg = value[wem_pkg::CC_W-1:0];
      default: ;
    endcase
  endtask

  // Offers one sample after a random gap (none when calm_send is set) and waits for its transfer.
  // Valid stays high on return, so the caller must offer the next sample or drain within the same time step.
  task automatic send_sample(input wem_pkg::in_t s, input bit typed,
                             input wem_pkg::out_t typed_res, output bit took);
    int            gap;
    bit            done;
    wem_pkg::out_t res;
    gap = calm_send ? 0 : $urandom_range(0, 14);
    cfg_we <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_metrics(s, took, done, res);
    if (done) pending_metrics.push_back(typed ? typed_res : res);
  endtask

  // Lets every expected result out, then waits out a full frame computation.
  task automatic drain_block();
    in_valid <= 1'b0;
    cfg_we <= 1'b0;
    while (pending_metrics.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [wem_pkg::CFG_W-1:0] pick_size();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return 13'h1FFF;
      2:       return 13'd4096;
      3, 4, 5: return wem_pkg::CFG_W'($urandom_range(1, 8191));
      default: return wem_pkg::CFG_W'($urandom_range(1, 48));
    endcase
  endfunction

  // Corners mostly land near the image so that windows are small and often partly outside.
  function automatic logic [wem_pkg::CFG_W-1:0] pick_corner(
    input logic [wem_pkg::CFG_W-1:0] size);
    int lim;
    lim = (size > MAX_DIM || size == 0) ? MAX_DIM : size;
    case ($urandom_range(0, 7))
      0:       return 13'h1000;
      1:       return 13'h0FFF;
      2:       return wem_pkg::CFG_W'($urandom_range(0, 8191));
      default: return wem_pkg::CFG_W'(int'($urandom_range(0, lim + 15)) - 8);
    endcase
  endfunction

  function automatic logic [wem_pkg::CFG_W-1:0] pick_channels();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return wem_pkg::CFG_W'($urandom_range(5, 7));
      default: return wem_pkg::CFG_W'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [wem_pkg::SAMPLE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return wem_pkg::SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Result side: random stall after each transfer (none when calm_recv is set), plus the long hold-off when asked.
  initial begin : result_sink
    int            hold_cnt;
    wem_pkg::out_t want;
    hold_cnt = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_metrics.size() == 0) begin
          $error("result transfer with nothing expected: %h", out_data);
          fail_count++;
        end else begin
          want = pending_metrics.pop_front();
          if (out_data.mean_abs_error !== want.mean_abs_error) begin
            $error("mean_abs_error: expected %0d, got %0d", want.mean_abs_error,
                   out_data.mean_abs_error);
            fail_count++;
          end
          if (out_data.rms_error !== want.rms_error) begin
            $error("rms_error: expected %0d, got %0d", want.rms_error, out_data.rms_error);
            fail_count++;
          end
          if (out_data.window_empty !== want.window_empty) begin
            $error("window_empty: expected %0d, got %0d", want.window_empty,
                   out_data.window_empty);
            fail_count++;
          end
          if (out_data.sample_count !== want.sample_count) begin
            $error("sample_count: expected %0d, got %0d", want.sample_count,
                   out_data.sample_count);
            fail_count++;
          end
        end
        hold_cnt = calm_recv ? 0 : $urandom_range(0, 14);
      end
      out_stall <= long_hold || (hold_cnt > 0);
      if (hold_cnt > 0) hold_cnt--;
    end
  end

  // Long receiver hold-off so that finished results back up into the sample input.
  initial begin : long_backpressure
    long_hold <= 1'b0;
    wait (press_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    row_t         row;
    wem_pkg::in_t s;
    bit           took, dirty, win_ok, noise;
    int           counted, phase, sent, phase_count, len, xl, xh, yl, yh, nch;
    logic [wem_pkg::CFG_W-1:0] w, h;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    corner_x1 = '0;
    corner_y1 = '0;
    corner_x2 = 13'd4095;
    corner_y2 = 13'd4095;
    img_w = 13'd4096;
    img_h = 13'd4096;
    chan_cfg = 3'd1;
    abs_sum = '0;
    sq_sum = '0;
    hit_count = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; register rows wait until the block has gone quiet.
    dirty = 1'b0;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        if (dirty) drain_block();
        dirty = 1'b0;
        write_reg(row.index, row.value);
      end else begin
        send_sample(row.sample, row.kind == ROW_CHECKED, row.result, took);
        dirty = 1'b1;
      end
    end

    // Random phases: a fresh window setup, then frames that mostly hit the window.
    counted = 0;
    phase = 0;
    while (counted < RANDOM_ITEMS) begin
      drain_block();
      w = pick_size();
      h = pick_size();
      write_reg(wem_pkg::REG_IMAGE_WIDTH, w);
      write_reg(wem_pkg::REG_IMAGE_HEIGHT, h);
      write_reg(wem_pkg::REG_CORNER1_X, pick_corner(w));
      write_reg(wem_pkg::REG_CORNER2_X, pick_corner(w));
      write_reg(wem_pkg::REG_CORNER1_Y, pick_corner(h));
      write_reg(wem_pkg::REG_CORNER2_Y, pick_corner(h));
      write_reg(wem_pkg::REG_CHANNEL_COUNT, pick_channels());
      calm_send = ($urandom_range(0, 3) == 0);
      calm_recv = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        calm_send = 1'b1;
        press_go = 1'b1;
      end
      win_ok = bound_axis(corner_x1, corner_x2, img_w, xl, xh);
      if (!bound_axis(corner_y1, corner_y2, img_h, yl, yh)) win_ok = 1'b0;
      nch = active_channels();
      phase_count = 0;
      sent = 0;
      while (phase_count < PHASE_ITEMS && sent < 4 * PHASE_ITEMS &&
             counted < RANDOM_ITEMS) begin
        // A few frames are noise: stray positions and a last marker at random.
        noise = ($urandom_range(0, 7) == 0);
        len = $urandom_range(1, 24);
        for (int k = 0; k < len; k++) begin
          s.sample_a = pick_value();
          s.sample_b = pick_value();
          if (!noise && win_ok && nch != 0 && $urandom_range(0, 9) < 8) begin
            s.pixel_x = wem_pkg::PIX_W'($urandom_range(xl, xh));
            s.pixel_y = wem_pkg::PIX_W'($urandom_range(yl, yh));
            s.channel = wem_pkg::CHAN_W'($urandom_range(0, nch - 1));
          end else begin
            s.pixel_x = wem_pkg::PIX_W'($urandom_range(0, 4095));
            s.pixel_y = wem_pkg::PIX_W'($urandom_range(0, 4095));
            s.channel = wem_pkg::CHAN_W'($urandom_range(0, 3));
          end
          s.last_sample = noise ? ($urandom_range(0, 15) == 0) : (k == len - 1);
          send_sample(s, 1'b0, '0, took);
          sent++;
          counted++;
          if (took || s.last_sample) phase_count++;
        end
      end
      phase++;
    end

    drain_block();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== window_error_metrics_top.f =====
rtl/wem_pkg.sv
rtl/wem_window.sv
rtl/wem_accum.sv
rtl/wem_cs_unit.sv
rtl/wem_seq.sv
rtl/window_error_metrics_top.sv
test/window_error_metrics_top_test.sv
